FILE: sv/mstb_pkg.sv
// Package for the multichannel step-tone bouncer.
// Holds the request types, function and register codes, and the controller types.
// No dependencies.
`default_nettype none

package mstb_pkg;

  // Function codes carried in the func field of an input request.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HEAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HEAD = 1'b1;

  localparam int unsigned POS_W = 16;
  localparam int unsigned PIN_W = 16;

  typedef struct packed {
    logic        func;
    logic [3:0]  channel;
    logic [15:0] period;
    logic        notes_active;
  } in_req_t;

  typedef struct packed {
    logic [15:0] step_pins;
    logic [15:0] dir_pins;
  } out_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RESP
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic set_per;   // store the period of the accepted request
    logic start;     // rewind the channel sweep
    logic rd_en;     // read one channel and advance the sweep
    logic load_out;  // capture the pin states into the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_last;   // the sweep is reading the last channel
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: sv/mstb_ctrl.sv
// Controller state machine of the multichannel step-tone bouncer.
// Depends on mstb_pkg for the state, command and status types.
`default_nettype none

module mstb_ctrl
  import mstb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     in_func,
  input  wire logic     in_notes_active,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_sts_t  sts,
  output ctl_cmd_t      cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_func == FUNC_SET) begin
            cmd.set_per = 1'b1;
            state_nxt   = ST_RESP;
          end else if (in_notes_active) begin
            cmd.start = 1'b1;
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SWEEP: begin
        cmd.rd_en = 1'b1;
        if (sts.rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: sv/mstb_dp.sv
// Datapath of the multichannel step-tone bouncer: period and counter memories,
// the per-channel step stage, pin registers and the output register. Uses mstb_pkg.
`default_nettype none

module mstb_dp
  import mstb_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire in_req_t              in_req,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [POS_W-1:0]     cfg_wdata,
  input  wire ctl_cmd_t             cmd,
  output dp_sts_t                   sts,
  output out_req_t                  out_req
);

  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [POS_W-1:0]   max_r, min_r;
  logic [POS_W-1:0]   per_mem [CHANNELS];
  logic [2*POS_W-1:0] st_mem  [CHANNELS];   // {tick count, head position}
  logic [CHANNELS-1:0] per_vld_r, st_vld_r;
  logic [CHANNELS-1:0] dir_r, dir_nxt, step_r, step_nxt;

  logic [IW-1:0]      rd_idx_r, wb_idx_r;
  logic               wb_vld_r;
  logic [POS_W-1:0]   per_q_r;
  logic [2*POS_W-1:0] st_q_r;
  logic               per_ok_r, st_ok_r;
  out_req_t           out_r;

  logic [6:0]       ch_ext;
  logic             ch_ok;
  logic [IW-1:0]    set_idx;
  logic [POS_W-1:0] per_c, cnt_c, head_c, cnt_n, head_n;
  logic             dir_c, do_step, flip, st_we;
  logic [PIN_W-1:0] step_pins_c, dir_pins_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= POS_W'(100);
      min_r <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == REG_MAX_HEAD) begin
        max_r <= cfg_wdata;
      end
      if (cfg_idx == REG_MIN_HEAD) begin
        min_r <= cfg_wdata;
      end
    end
  end

  assign ch_ext  = 7'(in_req.channel);
  assign ch_ok   = ch_ext < 7'(CHANNELS);
  assign set_idx = IW'(in_req.channel);

  // Sweep address and write-back stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      wb_vld_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_en) begin
        rd_idx_r <= rd_idx_r + IW'(1);
      end
      wb_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      wb_idx_r <= rd_idx_r;
      per_q_r  <= per_mem[rd_idx_r];
      st_q_r   <= st_mem[rd_idx_r];
      per_ok_r <= per_vld_r[rd_idx_r];
      st_ok_r  <= st_vld_r[rd_idx_r];
    end
  end

  assign sts.rd_last = (rd_idx_r == IW'(CHANNELS - 1));

  // Step stage: entries never written read as zero.
  always_comb begin
    per_c   = per_ok_r ? per_q_r : '0;
    cnt_c   = st_ok_r ? st_q_r[2*POS_W-1:POS_W] : '0;
    head_c  = st_ok_r ? st_q_r[POS_W-1:0] : '0;
    dir_c   = dir_r[wb_idx_r];
    st_we   = wb_vld_r && (per_c != '0);
    do_step = cnt_c >= per_c;
    head_n  = head_c;
    cnt_n   = cnt_c + POS_W'(1);
    flip    = 1'b0;
    if (do_step) begin
      head_n = dir_c ? (head_c - POS_W'(1)) : (head_c + POS_W'(1));
      cnt_n  = '0;
      flip   = (head_n == max_r) || (head_n == min_r);
    end
    dir_nxt  = dir_r;
    step_nxt = step_r;
    if (st_we && do_step) begin
      dir_nxt[wb_idx_r]  = dir_c ^ flip;
      step_nxt[wb_idx_r] = ~step_r[wb_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r     <= '0;
      step_r    <= '0;
      per_vld_r <= '0;
      st_vld_r  <= '0;
    end else begin
      dir_r  <= dir_nxt;
      step_r <= step_nxt;
      if (cmd.set_per && ch_ok) begin
        per_vld_r[set_idx] <= 1'b1;
      end
      if (st_we) begin
        st_vld_r[wb_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_per && ch_ok) begin
      per_mem[set_idx] <= in_req.period;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[wb_idx_r] <= {cnt_n, head_n};
    end
  end

  // Only the first sixteen channels reach the pins.
  for (genvar b = 0; b < PIN_W; b++) begin : g_pins
    if (b < CHANNELS) begin : g_on
      assign step_pins_c[b] = step_r[b];
      assign dir_pins_c[b]  = dir_r[b];
    end else begin : g_off
      assign step_pins_c[b] = 1'b0;
      assign dir_pins_c[b]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.step_pins <= step_pins_c;
      out_r.dir_pins  <= dir_pins_c;
    end
  end

  assign out_req = out_r;

endmodule

`default_nettype wire

FILE: sv/multichannel_step_tone_bouncer.sv
// Multichannel step-tone bouncer: a bank of per-channel period counters that
// toggle stepper step pins as tone generators and bounce each head between two
// limits. A set request stores one channel's period; a tick request with
// notes_active set sweeps the channels one per cycle through the period and
// counter memories before the result. Idle ticks and set requests skip the
// sweep and go straight to the result. Every request returns one result with
// all step and direction pins; a new request is taken while the previous
// result still waits in the output register.
`default_nettype none

module multichannel_step_tone_bouncer
  import mstb_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input request channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_req_t              in_req,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_req_t                  out_req,
  // Configuration writes: index 0 is the upper head limit, index 1 the lower.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [POS_W-1:0]     cfg_wdata
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // The controller sequences acceptance, the channel sweep and the result.
  mstb_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_req.func),
    .in_notes_active (in_req.notes_active),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sts             (sts),
    .cmd             (cmd)
  );

  // The datapath holds all channel state and the output register.
  mstb_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_req   (out_req)
  );

endmodule

`default_nettype wire

FILE: bench/pin_state_checker.sv
`timescale 1ns / 1ps
// Checker for the multichannel step-tone bouncer: watches the request, result and
// configuration ports, predicts the pin states and compares every result.
// Depends on mstb_pkg for the request types and register codes.

module pin_state_checker
  import mstb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_req_t              in_req,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_req_t             out_req,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [POS_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   pins_owed
);

  localparam int NCH = 16;

  logic [15:0] period_tab [NCH];
  logic [15:0] tick_cnt   [NCH];
  logic [15:0] head_pos   [NCH];
  logic [15:0] dir_mask;
  logic [15:0] step_mask;
  logic [15:0] lim_hi;
  logic [15:0] lim_lo;

  out_req_t expected_pins [$];

  // Applies one request to the channel bank and returns the pin states after it.
  function automatic out_req_t next_pin_state(input in_req_t r);
    out_req_t res;
    if (r.func == FUNC_SET) begin
      period_tab[r.channel] = r.period;
    end else if (r.notes_active) begin
      for (int ch = 0; ch < NCH; ch++) begin
        if (period_tab[ch] != 16'd0) begin
          if (tick_cnt[ch] >= period_tab[ch]) begin
            head_pos[ch] = dir_mask[ch] ? head_pos[ch] - 16'd1 : head_pos[ch] + 16'd1;
            if (head_pos[ch] == lim_hi || head_pos[ch] == lim_lo) begin
              dir_mask[ch] = ~dir_mask[ch];
            end
            step_mask[ch] = ~step_mask[ch];
            tick_cnt[ch]  = 16'd0;
          end else begin
            tick_cnt[ch] = tick_cnt[ch] + 16'd1;
          end
        end
      end
    end
    res.step_pins = step_mask;
    res.dir_pins  = dir_mask;
    return res;
  endfunction

  always @(posedge clk) begin
    out_req_t exp_pins;
    if (!rst_n) begin
      for (int ch = 0; ch < NCH; ch++) begin
        period_tab[ch] = 16'd0;
        tick_cnt[ch]   = 16'd0;
        head_pos[ch]   = 16'd0;
      end
      dir_mask   = 16'd0;
      step_mask  = 16'd0;
      lim_hi     = 16'd100;
      lim_lo     = 16'd0;
      mismatches = 0;
      expected_pins.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MAX_HEAD: lim_hi = cfg_wdata;
          REG_MIN_HEAD: lim_lo = cfg_wdata;
          default: ;
        endcase
      end
      // Results are checked before this edge's request is predicted, so a
      // result can never be matched against an expectation pushed at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_pins.size() == 0) begin
          $error("unexpected result: step_pins %h, dir_pins %h",
                 out_req.step_pins, out_req.dir_pins);
          mismatches++;
        end else begin
          exp_pins = expected_pins.pop_front();
          if (out_req.step_pins !== exp_pins.step_pins) begin
            $error("step_pins: expected %h, actual %h", exp_pins.step_pins, out_req.step_pins);
            mismatches++;
          end
          if (out_req.dir_pins !== exp_pins.dir_pins) begin
            $error("dir_pins: expected %h, actual %h", exp_pins.dir_pins, out_req.dir_pins);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_pins.push_back(next_pin_state(in_req));
      end
    end
    pins_owed = expected_pins.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Top of the bench for the multichannel step-tone bouncer: clock, reset, request
// and configuration stimulus, result-side stalls, watchdog and verdict.
// Depends on mstb_pkg, the block itself and pin_state_checker.

module tb;
  import mstb_pkg::*;

  localparam int SEG_REQS       = 305;   // random requests per limit setting
  localparam int HOLD_CYCLES    = 300;   // long result-side hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
  localparam int TAIL_CYCLES    = 60;    // settle time after the last result

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  in_req_t        in_req    = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  out_req_t       out_req;
  logic           cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = REG_MAX_HEAD;
  logic [POS_W-1:0]     cfg_wdata = '0;

  int mismatches;
  int pins_owed;

  // Idle percentages for the two sides; the stimulus process changes them per phase.
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  // The stimulus bumps hold_trig to ask the receiver for one long hold-off.
  int hold_trig    = 0;

  // Limit pairs, one per segment. They are ordered so that heads first bounce
  // near zero, then wrap downward past zero, then hit the full-scale extremes,
  // wrap upward past 65535, meet equal limits, and finally swapped extremes.
  logic [15:0] hi_lims [6] = '{16'd3, 16'd12, 16'hFFFF, 16'd5,     16'd7, 16'd0};
  logic [15:0] lo_lims [6] = '{16'd0, 16'd9,  16'd0,    16'd65400, 16'd7, 16'hFFFF};

  always #5 clk = ~clk;

  multichannel_step_tone_bouncer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  pin_state_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_req    (out_req),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pins_owed  (pins_owed)
  );

  function automatic in_req_t set_req(input logic [3:0] ch, input logic [15:0] per,
                                      input logic act);
    in_req_t r;
    r.func         = FUNC_SET;
    r.channel      = ch;
    r.period       = per;
    r.notes_active = act;
    return r;
  endfunction

  // A tick request carries random channel and period bits, which the block ignores.
  function automatic in_req_t tick_req(input logic act);
    in_req_t r;
    r.func         = FUNC_TICK;
    r.channel      = 4'($urandom_range(15));
    r.period       = 16'($urandom_range(16'hFFFF));
    r.notes_active = act;
    return r;
  endfunction

  // Mostly active ticks, so heads keep moving. Period writes favor short
  // periods; a few full-range ones park a channel with a long count, which a
  // later short period then cuts off on the next tick.
  function automatic in_req_t random_req();
    int          pick;
    logic [15:0] per;
    pick = $urandom_range(99);
    if (pick < 78) begin
      return tick_req($urandom_range(99) < 92);
    end
    pick = $urandom_range(99);
    if (pick < 12) per = 16'd0;
    else if (pick < 70) per = 16'($urandom_range(1, 4));
    else if (pick < 90) per = 16'($urandom_range(5, 40));
    else per = 16'($urandom_range(16'hFFFF));
    return set_req(4'($urandom_range(15)), per, 1'($urandom_range(1)));
  endfunction

  // Offers one request from a falling edge and returns at the falling edge after
  // it was accepted. Valid stays high between back-to-back requests.
  task automatic push_req(input in_req_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req   = r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stops offering requests until every predicted result has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (pins_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Result side: random stalls at the current percentage, or a long hold-off
  // when the stimulus asks for one. The hold-off is counted here, not by the
  // sender, so requests keep being offered while the block backs up.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Watchdog: any cycle with a request, result or register write restarts the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("multichannel_step_tone_bouncer: mismatch");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests at the reset limits (upper 100, lower 0).
    push_req(tick_req(1'b1));                  // all channels silent, pins stay low
    push_req(set_req(4'd0, 16'd1, 1'b0));      // notes flag does not matter for a set
    push_req(set_req(4'd15, 16'hFFFF, 1'b1));  // longest period, all period bits high
    push_req(set_req(4'd5, 16'd2, 1'b1));
    push_req(set_req(4'd10, 16'd0, 1'b0));     // explicit silence
    push_req(tick_req(1'b1));
    push_req(tick_req(1'b1));
    push_req(tick_req(1'b1));
    push_req(tick_req(1'b0));                  // no notes sounding, nothing moves
    push_req(tick_req(1'b1));
    push_req(tick_req(1'b1));
    push_req(set_req(4'd15, 16'd1, 1'b0));     // period now below the running count
    push_req(tick_req(1'b1));                  // so channel 15 toggles right away
    push_req(set_req(4'd0, 16'd0, 1'b1));      // silencing keeps the pin levels
    push_req(tick_req(1'b1));
    push_req(tick_req(1'b1));
    push_req(tick_req(1'b1));

    // Three idling profiles, each over two limit settings.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 21;
          rcv_idle_pct = 66;
        end
        1: begin
          snd_idle_pct = 66;
          rcv_idle_pct = 21;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        drain();
        write_reg(REG_MAX_HEAD, hi_lims[phase * 2 + seg]);
        write_reg(REG_MIN_HEAD, lo_lims[phase * 2 + seg]);
        // With no random stalls the long hold-off is what backs the block up.
        if (phase == 2 && seg == 0) hold_trig++;
        repeat (SEG_REQS) push_req(random_req());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pins_owed == 0) begin
      $display("multichannel_step_tone_bouncer: match");
    end else begin
      $display("multichannel_step_tone_bouncer: mismatch");
    end
    $finish;
  end

endmodule
